// File: hdl/tlbpt_pkg.sv
// Shared types and constants for the TLB and page table translation block.
`timescale 1ns / 1ps

package tlbpt_pkg;

    localparam int VA_WIDTH          = 16;
    localparam int FRAME_INDEX_WIDTH = 8;
    localparam int S_TDATA_WIDTH     = 16;
    localparam int M_TDATA_WIDTH     = 32;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } tlbpt_state_t;

endpackage

// File: hdl/tlbpt_tlb.sv
// Fully associative TLB with parallel tag compare and FIFO replacement.
`timescale 1ns / 1ps

module tlbpt_tlb #(
    parameter int ENTRIES   = 16,
    parameter int PAGE_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [PAGE_BITS-1:0] lookup_page,
    output logic                 lookup_hit,
    output logic [PAGE_BITS-1:0] lookup_frame,
    input  logic                 fill_en,
    input  logic [PAGE_BITS-1:0] fill_page,
    input  logic [PAGE_BITS-1:0] fill_frame
);

    localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [PAGE_BITS-1:0] tag_reg   [ENTRIES];
    logic [PAGE_BITS-1:0] frame_reg [ENTRIES];
    logic [ENTRIES-1:0]   valid_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic [PTR_W-1:0]     ptr_next;

    // Lowest matching index wins.
    always_comb begin
        lookup_hit   = 1'b0;
        lookup_frame = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && (tag_reg[i] == lookup_page)) begin
                lookup_hit   = 1'b1;
                lookup_frame = frame_reg[i];
            end
        end
    end

    always_comb begin
        if (ptr_reg == PTR_W'(ENTRIES - 1)) begin
            ptr_next = '0;
        end else begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end else if (fill_en) begin
            valid_reg[ptr_reg] <= 1'b1;
            ptr_reg            <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fill_en) begin
            tag_reg[ptr_reg]   <= fill_page;
            frame_reg[ptr_reg] <= fill_frame;
        end
    end

endmodule

// File: hdl/tlb_page_table_translation_top.sv
// Top level: virtual to physical translation through a TLB and a page map memory.
//
//  channel | dir | tdata fields (low bit up)                          | tlast | tuser
//  s_      | in  | virtual_address[15:0]                              | -     | -
//  m_      | out | phys_addr[15:0] frame_index[23:16]                 | -     | -
//          |     | tlb_hit[24] page_fault[25], zero fill to 32 bits   |       |
//
// Each item goes through two steps: the synchronous page map read in IDLE, then in
// LOOKUP the TLB compare, the page map write-back on a fault and the TLB fill.
// After reset a clearing pass walks all 2^PAGE_NUMBER_BITS page map entries
// (256 by default), with s_tready low.
// The result sits in an output register; a new item is taken while it waits,
// and that item holds in lookup until the register frees up.
`timescale 1ns / 1ps

module tlb_page_table_translation_top #(
    parameter int TLB_ENTRIES      = 16,
    parameter int OFFSET_BITS      = 8,
    parameter int PAGE_NUMBER_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tlbpt_pkg::S_TDATA_WIDTH-1:0] s_tdata,  // virtual_address
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // phys_addr, frame_index, tlb_hit, page_fault
    output logic [tlbpt_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

    localparam int VA_W      = tlbpt_pkg::VA_WIDTH;
    localparam int FI_W      = tlbpt_pkg::FRAME_INDEX_WIDTH;
    localparam int PNB       = PAGE_NUMBER_BITS;
    localparam int MAP_DEPTH = 1 << PNB;
    localparam logic [VA_W-1:0] OFFSET_MASK = VA_W'((32'd1 << OFFSET_BITS) - 32'd1);

    tlbpt_pkg::tlbpt_state_t state_reg, state_next;

    logic [PNB-1:0]  clr_idx_reg, clr_idx_next;
    logic [VA_W-1:0] va_reg;
    logic [PNB:0]    next_free_reg, next_free_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [tlbpt_pkg::M_TDATA_WIDTH-1:0] m_tdata_reg, m_tdata_next;

    logic [PNB:0]    map_mem [MAP_DEPTH];
    logic [PNB:0]    map_rdata_reg;
    logic            map_re;
    logic [PNB-1:0]  map_raddr;
    logic            map_we;
    logic [PNB-1:0]  map_waddr;
    logic [PNB:0]    map_wdata;

    logic [VA_W-1:0] s_shift;
    logic [VA_W-1:0] va_shift;
    logic [PNB-1:0]  page;
    logic            tlb_hit;
    logic [PNB-1:0]  tlb_frame;
    logic            tlb_fill;
    logic            fault;
    logic [PNB-1:0]  frame;
    logic [VA_W-1:0] phys_addr;
    logic            out_free;
    logic            s_xfer;

    assign s_shift   = s_tdata >> OFFSET_BITS;
    assign va_shift  = va_reg >> OFFSET_BITS;
    assign page      = va_shift[PNB-1:0];
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign map_re    = s_xfer;
    assign map_raddr = s_shift[PNB-1:0];

    tlbpt_tlb #(
        .ENTRIES   (TLB_ENTRIES),
        .PAGE_BITS (PNB)
    ) u_tlb (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .lookup_page  (page),
        .lookup_hit   (tlb_hit),
        .lookup_frame (tlb_frame),
        .fill_en      (tlb_fill),
        .fill_page    (page),
        .fill_frame   (frame)
    );

    always_comb begin
        fault = 1'b0;
        if (tlb_hit) begin
            frame = tlb_frame;
        end else if (map_rdata_reg[PNB]) begin
            frame = map_rdata_reg[PNB-1:0];
        end else begin
            frame = next_free_reg[PNB-1:0];
            fault = 1'b1;
        end
        phys_addr = (VA_W'(frame) << OFFSET_BITS) + (va_reg & OFFSET_MASK);
    end

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        next_free_next = next_free_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        s_tready       = 1'b0;
        tlb_fill       = 1'b0;
        map_we         = 1'b0;
        map_waddr      = page;
        map_wdata      = {1'b1, frame};
        unique case (state_reg)
            tlbpt_pkg::ST_CLEAR: begin
                map_we       = 1'b1;
                map_waddr    = clr_idx_reg;
                map_wdata    = '0;
                clr_idx_next = clr_idx_reg + PNB'(1);
                if (clr_idx_reg == {PNB{1'b1}}) begin
                    state_next = tlbpt_pkg::ST_IDLE;
                end
            end
            tlbpt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = tlbpt_pkg::ST_LOOKUP;
                end
            end
            tlbpt_pkg::ST_LOOKUP: begin
                if (out_free) begin
                    state_next    = tlbpt_pkg::ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = tlbpt_pkg::M_TDATA_WIDTH'(
                        {fault, tlb_hit, FI_W'(frame), phys_addr});
                    tlb_fill      = !tlb_hit;
                    map_we        = fault;
                    if (fault && (next_free_reg != (PNB + 1)'(MAP_DEPTH))) begin
                        next_free_next = next_free_reg + (PNB + 1)'(1);
                    end
                end
            end
            default: begin
                state_next = tlbpt_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tlbpt_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            next_free_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            next_free_reg <= next_free_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (s_xfer) begin
            va_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            map_rdata_reg <= map_mem[map_raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
